// ===== hw/rtl/sexl_pkg.sv =====
// Shared types, character codes and byte classifiers for the S-expression lexer.
// Used by the front, queue, back and top-level files; depends on nothing else.
package sexl_pkg;

    // Widths of the result fields.
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 6;
    localparam int NUM_W  = 31;
    localparam int ERR_W  = 2;

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUOTE  = 3'd0,
        KIND_LPAREN = 3'd1,
        KIND_RPAREN = 3'd2,
        KIND_IDENT  = 3'd3,
        KIND_NUM    = 3'd4,
        KIND_STRING = 3'd5,
        KIND_EOL    = 3'd6,
        KIND_ERROR  = 3'd7
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_NUL_STR  = 2'd2,
        ERR_LF_STR   = 2'd3
    } t_err;

    // One command from the front to the back: a single result, or a text replay.
    typedef struct packed {
        t_kind             kind;
        logic              replay;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [NUM_W-1:0]  num;
        t_err              err;
    } t_cmd;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
        logic replay_pending;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return (c inside {[CH_BANG:CH_TILDE]}) &&
               (c != CH_LPAREN) && (c != CH_RPAREN) && (c != CH_DQUOTE);
    endfunction

endpackage

// ===== hw/rtl/sexl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the token text buffer; no dependencies.
module sexl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sexl_front.sv =====
// Lexer front: accepts bytes, tracks the lexer mode, fills the text buffer
// and issues result commands. Depends on sexl_pkg.
module sexl_front
    import sexl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 32,
    localparam int ADDR_W = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_in_byte,
    input  t_qstat            i_qstat,
    input  logic              i_back_busy,
    output logic              o_push,
    output t_cmd              o_push_cmd,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [7:0]        o_wdata
);

    typedef enum logic [4:0] {
        MODE_TOP   = 5'b00001,
        MODE_IDENT = 5'b00010,
        MODE_NUM   = 5'b00100,
        MODE_STR   = 5'b01000,
        MODE_DROP  = 5'b10000
    } t_mode;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_CHARS);

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_count, n_count;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic             r_hold_valid;
    t_cmd             r_hold;

    logic             accept;
    logic             c0_v, c1_v;
    t_cmd             cmd0, cmd1;
    logic             we_c;
    logic             wr_start;
    logic [7:0]       c;

    // Top-level handling of a byte, shared by the identifier, number and top-level modes.
    logic             t_valid;
    t_kind            t_kind_c;
    t_mode            t_mode_c;
    logic [LEN_W-1:0] t_count;
    logic [NUM_W-1:0] t_acc;
    logic             t_we;

    logic [NUM_W+3:0] prod;
    logic [NUM_W-1:0] acc_next;
    logic             full;

    assign c    = i_in_byte;
    assign full = (r_count >= MAX_LEN);

    // Decimal step with saturation: acc * 10 + digit.
    always_comb begin
        prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {{NUM_W{1'b0}}, c[3:0]};
        acc_next = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[NUM_W-1:0];
    end

    // Classification of a byte seen at the top level.
    always_comb begin
        t_valid  = 1'b1;
        t_kind_c = KIND_EOL;
        t_mode_c = MODE_TOP;
        t_count  = '0;
        t_acc    = '0;
        t_we     = 1'b0;
        if (c == CH_NUL || c == CH_LF) begin
            t_kind_c = KIND_EOL;
        end else if (c == CH_QUOTE) begin
            t_kind_c = KIND_QUOTE;
        end else if (c == CH_LPAREN) begin
            t_kind_c = KIND_LPAREN;
        end else if (c == CH_RPAREN) begin
            t_kind_c = KIND_RPAREN;
        end else begin
            t_valid = 1'b0;
            if (c == CH_DQUOTE) begin
                t_mode_c = MODE_STR;
            end else if (is_digit(c)) begin
                t_mode_c = MODE_NUM;
                t_acc    = {{(NUM_W-4){1'b0}}, c[3:0]};
                t_count  = LEN_W'(1);
            end else if (is_ident_char(c)) begin
                t_mode_c = MODE_IDENT;
                t_count  = LEN_W'(1);
                t_we     = 1'b1;
            end
        end
    end

    // Per-mode next state and commands for the byte on the input.
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_acc    = r_acc;
        c0_v     = 1'b0;
        c1_v     = 1'b0;
        cmd0     = '0;
        cmd1     = '0;
        we_c     = 1'b0;
        wr_start = 1'b0;

        cmd1.kind = t_kind_c;
        cmd1.last = 1'b1;

        case (r_mode)
            MODE_IDENT: begin
                if (is_ident_char(c)) begin
                    if (full) begin
                        c0_v     = 1'b1;
                        cmd0.kind = KIND_ERROR;
                        cmd0.err  = ERR_TOO_LONG;
                        n_mode   = MODE_DROP;
                        n_count  = '0;
                        n_acc    = '0;
                    end else begin
                        we_c    = 1'b1;
                        n_count = r_count + LEN_W'(1);
                    end
                end else begin
                    c0_v        = 1'b1;
                    cmd0.kind   = KIND_IDENT;
                    cmd0.replay = 1'b1;
                    cmd0.len    = r_count;
                    c1_v        = t_valid;
                    n_mode      = t_mode_c;
                    n_count     = t_count;
                    n_acc       = t_acc;
                    we_c        = t_we;
                    wr_start    = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(c)) begin
                    if (full) begin
                        c0_v      = 1'b1;
                        cmd0.kind = KIND_ERROR;
                        cmd0.err  = ERR_TOO_LONG;
                        n_mode    = MODE_DROP;
                        n_count   = '0;
                        n_acc     = '0;
                    end else begin
                        n_acc   = acc_next;
                        n_count = r_count + LEN_W'(1);
                    end
                end else begin
                    c0_v      = 1'b1;
                    cmd0.kind = KIND_NUM;
                    cmd0.num  = r_acc;
                    c1_v      = t_valid;
                    n_mode    = t_mode_c;
                    n_count   = t_count;
                    n_acc     = t_acc;
                    we_c      = t_we;
                    wr_start  = 1'b1;
                end
            end
            MODE_STR: begin
                if (c == CH_NUL || c == CH_LF) begin
                    c0_v      = 1'b1;
                    cmd0.kind = KIND_ERROR;
                    cmd0.err  = (c == CH_NUL) ? ERR_NUL_STR : ERR_LF_STR;
                    n_mode    = MODE_TOP;
                    n_count   = '0;
                end else if (c == CH_DQUOTE) begin
                    c0_v        = 1'b1;
                    cmd0.kind   = KIND_STRING;
                    cmd0.replay = 1'b1;
                    cmd0.len    = r_count;
                    n_mode      = MODE_TOP;
                    n_count     = '0;
                end else if (full) begin
                    c0_v      = 1'b1;
                    cmd0.kind = KIND_ERROR;
                    cmd0.err  = ERR_TOO_LONG;
                    n_mode    = MODE_DROP;
                    n_count   = '0;
                    n_acc     = '0;
                end else begin
                    we_c    = 1'b1;
                    n_count = r_count + LEN_W'(1);
                end
            end
            MODE_DROP: begin
                if (c == CH_NUL || c == CH_LF) begin
                    n_mode = MODE_TOP;
                end
            end
            default: begin
                c0_v      = t_valid;
                cmd0.kind = t_kind_c;
                n_mode    = t_mode_c;
                n_count   = t_count;
                n_acc     = t_acc;
                we_c      = t_we;
                wr_start  = 1'b1;
            end
        endcase

        // The first command closes the byte's run unless a second follows.
        cmd0.last = !c1_v;
    end

    // Hold off new bytes while a second command waits, the queue is full,
    // or buffered text is still pending or being replayed.
    assign o_stall = r_hold_valid || i_qstat.full || i_qstat.replay_pending || i_back_busy;
    assign accept  = i_valid && !o_stall;

    // Queue push: the held second command first, else the new first command.
    assign o_push     = r_hold_valid ? !i_qstat.full : (accept && c0_v);
    assign o_push_cmd = r_hold_valid ? r_hold : cmd0;

    // Text buffer write port.
    assign o_we    = accept && we_c;
    assign o_waddr = wr_start ? '0 : r_count[ADDR_W-1:0];
    assign o_wdata = c;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TOP;
            r_count      <= '0;
            r_acc        <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_acc   <= n_acc;
            end
            if (accept && c1_v) begin
                r_hold_valid <= 1'b1;
            end else if (r_hold_valid && !i_qstat.full) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // Second command payload.
    always_ff @(posedge i_clk) begin
        if (accept && c1_v) begin
            r_hold <= cmd1;
        end
    end

endmodule

// ===== hw/rtl/sexl_queue.sv =====
// Two-entry command queue between the lexer front and back.
// Depends on sexl_pkg.
module sexl_queue
    import sexl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_push_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_qstat
);

    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_push_cmd;
        end
    end

    // Status: a replay anywhere in the queue keeps the text buffer busy.
    assign o_head                 = r_ent[r_rp];
    assign o_qstat.full           = (r_cnt == 2'd2);
    assign o_qstat.empty          = (r_cnt == 2'd0);
    assign o_qstat.replay_pending = ((r_cnt != 2'd0) && r_ent[r_rp].replay) ||
                                    ((r_cnt == 2'd2) && r_ent[!r_rp].replay);

endmodule

// ===== hw/rtl/sexl_back.sv =====
// Lexer back: executes queued commands, replays buffered text one character
// per result and holds the output register. Depends on sexl_pkg.
module sexl_back
    import sexl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 32,
    localparam int ADDR_W = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_head,
    input  t_qstat            i_qstat,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [CHAR_W-1:0] o_text_char,
    output logic [LEN_W-1:0]  o_text_length,
    output logic [NUM_W-1:0]  o_number_value,
    output logic [ERR_W-1:0]  o_error_code,
    output logic              o_last_of_run
);

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_READ = 3'b010,
        BS_SHOW = 3'b100
    } t_bstate;

    t_bstate          r_state, n_state;
    logic             r_replay;
    logic             r_last_cmd;
    logic [LEN_W-1:0] r_idx, n_idx;
    t_kind            r_kind;
    logic [LEN_W-1:0] r_len;
    logic [NUM_W-1:0] r_num;
    t_err             r_err;
    logic [7:0]       r_char;
    logic             r_last;

    logic pop_text;
    logic more;

    assign o_pop    = (r_state == BS_IDLE) && !i_qstat.empty;
    assign pop_text = o_pop && i_head.replay && (i_head.len != '0);
    assign more     = r_replay && ((r_idx + LEN_W'(1)) < r_len);

    // Sequencer and text read address.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_re    = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (o_pop) begin
                    if (pop_text) begin
                        n_state = BS_READ;
                        n_idx   = '0;
                        o_re    = 1'b1;
                    end else begin
                        n_state = BS_SHOW;
                    end
                end
            end
            BS_READ: begin
                n_state = BS_SHOW;
            end
            BS_SHOW: begin
                if (!i_stall) begin
                    if (more) begin
                        n_state = BS_READ;
                        n_idx   = r_idx + LEN_W'(1);
                        o_re    = 1'b1;
                    end else begin
                        n_state = BS_IDLE;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_raddr = n_idx[ADDR_W-1:0];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_replay <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_replay <= pop_text;
            end
        end
    end

    // Output register and replay bookkeeping.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_kind     <= i_head.kind;
            r_len      <= i_head.len;
            r_num      <= i_head.num;
            r_err      <= i_head.err;
            r_last_cmd <= i_head.last;
            r_char     <= '0;
            r_last     <= i_head.last;
        end else if (r_state == BS_READ) begin
            r_char <= i_rdata;
            r_last <= r_last_cmd && (r_idx == (r_len - LEN_W'(1)));
        end
    end

    assign o_busy         = (r_state != BS_IDLE) && r_replay;
    assign o_valid        = (r_state == BS_SHOW);
    assign o_token_kind   = r_kind;
    assign o_text_char    = r_char;
    assign o_text_length  = r_len;
    assign o_number_value = r_num;
    assign o_error_code   = r_err;
    assign o_last_of_run  = r_last;

endmodule

// ===== hw/rtl/s_expression_byte_lexer.sv =====
// S-expression byte lexer: one source byte per item, tokens out as result items.
// Results pass through the command queue and the back's output register, text characters
// also through a buffer read. New bytes are taken while the back shows earlier results,
// but wait while text is pending or replays, a second result is held or the queue is full.
// Reset: synchronous, active low, clears mode, counters, queue and sequencer;
// the text buffer is not cleared, and only written entries are ever read.
module s_expression_byte_lexer
    import sexl_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_in_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [CHAR_W-1:0] o_text_char,
    output logic [LEN_W-1:0]  o_text_length,
    output logic [NUM_W-1:0]  o_number_value,
    output logic [ERR_W-1:0]  o_error_code,
    output logic              o_last_of_run
);

    localparam int ADDR_W = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1;

    t_qstat            qstat;
    t_cmd              push_cmd, head;
    logic              push, pop;
    logic              back_busy;
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata, rdata;

    // Front: byte acceptance and classification.
    sexl_front #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_qstat     (qstat),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_push_cmd  (push_cmd),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    // Command queue.
    sexl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_qstat    (qstat)
    );

    // Token text buffer.
    sexl_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TOKEN_CHARS)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Back: command execution and output register.
    sexl_back #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_text_char    (o_text_char),
        .o_text_length  (o_text_length),
        .o_number_value (o_number_value),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

`ifndef SYNTHESIS
    // The text buffer is never written while buffered text is still pending or replaying.
    a_no_write_during_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (!qstat.replay_pending && !back_busy))
        else $error("text buffer written during replay");

    // The front never pushes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("command pushed into full queue");

    // An error result always carries a nonzero error code.
    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind == KIND_ERROR)) |-> (o_error_code != ERR_NONE))
        else $error("error result without code");

    // Only identifier and string results carry a text length.
    a_length_only_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_text_length != '0)) |->
            ((o_token_kind == KIND_IDENT) || (o_token_kind == KIND_STRING)))
        else $error("text length on non-text result");
`endif

endmodule

// ===== tb/lexer_token_checker.sv =====
// Checker for the S-expression byte lexer: predicts result items from accepted bytes.
// Watches both channels and compares every accepted result with the oldest prediction.
// Depends on sexl_pkg for field widths, character codes and the kind and error enums.
module lexer_token_checker
    import sexl_pkg::*;
#(
    parameter int MAX_CHARS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [KIND_W-1:0] i_token_kind,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic [LEN_W-1:0]  i_text_length,
    input  logic [NUM_W-1:0]  i_number_value,
    input  logic [ERR_W-1:0]  i_error_code,
    input  logic              i_last_of_run,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_checked
);

    typedef enum logic [2:0] {
        SCAN_TOP,
        SCAN_IDENT,
        SCAN_NUM,
        SCAN_STR,
        SCAN_DROP
    } t_scan;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [NUM_W-1:0]  num;
        t_err              err;
        logic              last;
    } t_token;

    // Predicted lexer state.
    t_scan            scan_mode;
    int               held;
    logic [7:0]       text_buf [MAX_CHARS];
    logic [NUM_W-1:0] num_acc;

    // Result items predicted but not yet seen, oldest first.
    t_token tokens_due [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic bit ident_byte(input logic [7:0] c);
        return c >= CH_BANG && c <= CH_TILDE &&
               c != CH_LPAREN && c != CH_RPAREN && c != CH_DQUOTE;
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void emit(input t_kind kind, input logic [7:0] ch, input int len,
                                 input logic [NUM_W-1:0] num, input t_err err);
        t_token t;
        t.kind = kind;
        t.ch   = ch;
        t.len  = LEN_W'(len);
        t.num  = num;
        t.err  = err;
        t.last = 1'b0;
        tokens_due.push_back(t);
    endfunction

    // Buffered text goes out one character per item; empty text is a single item.
    function automatic void emit_text(input t_kind kind);
        if (held == 0) begin
            emit(kind, 8'h00, 0, '0, ERR_NONE);
        end else begin
            for (int i = 0; i < held; i++)
                emit(kind, text_buf[i], held, '0, ERR_NONE);
        end
    endfunction

    function automatic void overflow_token();
        scan_mode = SCAN_DROP;
        held      = 0;
        num_acc   = '0;
        emit(KIND_ERROR, 8'h00, 0, '0, ERR_TOO_LONG);
    endfunction

    // A byte seen at the top level, either fresh or the one that ended a token.
    function automatic void start_token(input logic [7:0] c);
        scan_mode = SCAN_TOP;
        held      = 0;
        num_acc   = '0;
        if (c == CH_NUL || c == CH_LF) begin
            emit(KIND_EOL, 8'h00, 0, '0, ERR_NONE);
        end else if (c == CH_QUOTE) begin
            emit(KIND_QUOTE, 8'h00, 0, '0, ERR_NONE);
        end else if (c == CH_LPAREN) begin
            emit(KIND_LPAREN, 8'h00, 0, '0, ERR_NONE);
        end else if (c == CH_RPAREN) begin
            emit(KIND_RPAREN, 8'h00, 0, '0, ERR_NONE);
        end else if (c == CH_DQUOTE) begin
            scan_mode = SCAN_STR;
        end else if (digit_byte(c)) begin
            scan_mode = SCAN_NUM;
            num_acc   = NUM_W'(c - CH_ZERO);
            held      = 1;
        end else if (ident_byte(c)) begin
            scan_mode   = SCAN_IDENT;
            text_buf[0] = c;
            held        = 1;
        end
    endfunction

    // Advance the predicted state by one byte and queue the items it causes.
    function automatic void lex_byte(input logic [7:0] c);
        int              n_prior;
        longint unsigned grown;
        t_token          tail;
        n_prior = tokens_due.size();
        case (scan_mode)
            SCAN_IDENT: begin
                if (ident_byte(c)) begin
                    if (held >= MAX_CHARS) begin
                        overflow_token();
                    end else begin
                        text_buf[held] = c;
                        held++;
                    end
                end else begin
                    emit_text(KIND_IDENT);
                    start_token(c);
                end
            end
            SCAN_NUM: begin
                if (digit_byte(c)) begin
                    if (held >= MAX_CHARS) begin
                        overflow_token();
                    end else begin
                        grown   = 64'(num_acc) * 64'd10 + 64'(c - CH_ZERO);
                        num_acc = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[NUM_W-1:0];
                        held++;
                    end
                end else begin
                    emit(KIND_NUM, 8'h00, 0, num_acc, ERR_NONE);
                    start_token(c);
                end
            end
            SCAN_STR: begin
                if (c == CH_NUL || c == CH_LF) begin
                    emit(KIND_ERROR, 8'h00, 0, '0, (c == CH_NUL) ? ERR_NUL_STR : ERR_LF_STR);
                    scan_mode = SCAN_TOP;
                    held      = 0;
                end else if (c == CH_DQUOTE) begin
                    emit_text(KIND_STRING);
                    scan_mode = SCAN_TOP;
                    held      = 0;
                end else if (held >= MAX_CHARS) begin
                    overflow_token();
                end else begin
                    text_buf[held] = c;
                    held++;
                end
            end
            SCAN_DROP: begin
                if (c == CH_NUL || c == CH_LF)
                    scan_mode = SCAN_TOP;
            end
            default: begin
                start_token(c);
            end
        endcase
        // The final item caused by this byte carries the last flag.
        if (tokens_due.size() > n_prior) begin
            tail      = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endfunction

    // Predict on accepted bytes, compare on accepted results.
    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            scan_mode = SCAN_TOP;
            held      = 0;
            num_acc   = '0;
            tokens_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                lex_byte(i_in_byte);
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (tokens_due.size() == 0) begin
                    $error("result item with kind %0d arrived with none expected",
                           i_token_kind);
                    o_mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.kind, i_token_kind);
                    check_field("text_char", want.ch, i_text_char);
                    check_field("text_length", want.len, i_text_length);
                    check_field("number_value", want.num, i_number_value);
                    check_field("error_code", want.err, i_error_code);
                    check_field("last_of_run", want.last, i_last_of_run);
                end
            end
        end
        o_pending <= tokens_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the S-expression byte lexer testbench: clock, reset, byte stimulus and verdict.
// Depends on sexl_pkg, the s_expression_byte_lexer RTL and tb/lexer_token_checker.sv.
module tb_top
    import sexl_pkg::*;
();

    localparam int BYTE_GOAL   = 230;
    localparam int QUIET_AFTER = 190;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_in_byte;
    logic              o_valid;
    logic              i_stall;
    logic [KIND_W-1:0] o_token_kind;
    logic [CHAR_W-1:0] o_text_char;
    logic [LEN_W-1:0]  o_text_length;
    logic [NUM_W-1:0]  o_number_value;
    logic [ERR_W-1:0]  o_error_code;
    logic              o_last_of_run;

    int mismatches;
    int pending;
    int checked;
    int bytes_sent;
    bit quiet;

    s_expression_byte_lexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_text_char    (o_text_char),
        .o_text_length  (o_text_length),
        .o_number_value (o_number_value),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    lexer_token_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_byte      (i_in_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_token_kind   (o_token_kind),
        .i_text_char    (o_text_char),
        .i_text_length  (o_text_length),
        .i_number_value (o_number_value),
        .i_error_code   (o_error_code),
        .i_last_of_run  (o_last_of_run),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: stall bursts with calm stretches, none in the last part of the run.
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Offer one byte, possibly after an idle burst, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && ((bytes_sent / 24) % 3 != 2) && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        if (bytes_sent >= QUIET_AFTER)
            quiet = 1'b1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_ident_char(input bit first);
        logic [7:0] c;
        c = 8'($urandom_range(CH_BANG, CH_TILDE));
        while (c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE ||
               (first && (c == CH_QUOTE || is_digit(c))))
            c = 8'($urandom_range(CH_BANG, CH_TILDE));
        return c;
    endfunction

    // Any byte that can sit inside a string without closing or breaking it.
    function automatic logic [7:0] pick_string_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_DQUOTE || c == CH_LF)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Mostly short text, now and then close to the buffer size.
    function automatic int pick_len(input int shortest);
        return ($urandom_range(0, 5) == 0) ? $urandom_range(24, 32)
                                           : $urandom_range(shortest, 6);
    endfunction

    task automatic send_ident(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pick_ident_char(i == 0));
    endtask

    task automatic send_number(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic send_string(input int len, input logic [7:0] closer);
        send_byte(CH_DQUOTE);
        for (int i = 0; i < len; i++)
            send_byte(pick_string_char());
        send_byte(closer);
    endtask

    task automatic send_line_end();
        send_byte($urandom_range(0, 1) ? CH_LF : CH_NUL);
    endtask

    // A token one or more characters past the buffer, some dropped bytes, then a line end.
    task automatic send_overlong();
        int len;
        len = $urandom_range(33, 36);
        case ($urandom_range(0, 2))
            0: send_ident(len);
            1: send_number(len);
            default: begin
                send_byte(CH_DQUOTE);
                for (int i = 0; i < len; i++)
                    send_byte(pick_string_char());
            end
        endcase
        repeat ($urandom_range(0, 4)) send_byte(pick_string_char());
        send_line_end();
    endtask

    initial begin
        logic [7:0] closer;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in_byte  <= 8'h00;
        bytes_sent = 0;
        quiet      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: punctuation, ignored bytes, empty string, string broken by LF
        // and by NUL, a saturating number, and an identifier holding a digit.
        send_text("'() ");
        send_byte(8'hFF);
        send_text("\"\"\"~");
        send_byte(CH_LF);
        send_text("\"!");
        send_byte(CH_NUL);
        send_text("4294967295)a0");
        send_byte(CH_LF);

        // Random token streams with some noise and broken tokens mixed in.
        while (bytes_sent < BYTE_GOAL) begin
            case ($urandom_range(0, 15))
                0, 1, 2: send_ident(pick_len(1));
                3, 4: send_number(($urandom_range(0, 3) == 0) ? $urandom_range(10, 12)
                                                              : $urandom_range(1, 5));
                5, 6, 7: begin
                    case ($urandom_range(0, 5))
                        0: closer = CH_LF;
                        1: closer = CH_NUL;
                        default: closer = CH_DQUOTE;
                    endcase
                    send_string(pick_len(0), closer);
                end
                8: send_byte(CH_QUOTE);
                9: send_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
                10: send_byte(8'h20);
                11: send_line_end();
                12: send_overlong();
                13: send_byte(8'($urandom_range(8'h7F, 8'hFF)));
                14: send_byte(8'($urandom_range(1, 8'h1F)));
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        i_valid <= 1'b0;

        // Drain: let the last prediction settle, then wait for every expected item.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run sent %0d source bytes and checked %0d result items.",
                 bytes_sent, checked);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sexl_pkg.sv
hw/rtl/sexl_ram.sv
hw/rtl/sexl_front.sv
hw/rtl/sexl_queue.sv
hw/rtl/sexl_back.sv
hw/rtl/s_expression_byte_lexer.sv
tb/lexer_token_checker.sv
tb/tb_top.sv
